/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

/* rtl/dsc_pkg.sv */
`default_nettype none
package dsc_pkg;

  localparam int ADDR_W     = 64;
  localparam int SLOT_OUT_W = 7;
  localparam int SLOT_ID_W  = 10;

  typedef logic [SLOT_ID_W-1:0] slot_id_t;

  // Scan record carried down the cell chain for one transaction.
  typedef struct packed {
    logic     tok;
    logic     hit_f;
    slot_id_t hit_idx;
    logic     hi_f;
    slot_id_t hi_idx;
    logic     lo_f;
    slot_id_t lo_idx;
  } scan_rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

/* rtl/dsc_cell.sv */
`default_nettype none
module dsc_cell #(
  parameter int INDEX = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dsc_pkg::scan_rec_t            rec_in,
  input  wire logic [dsc_pkg::ADDR_W-1:0]    addr,
  input  wire dsc_pkg::slot_id_t             ptr,
  input  wire logic                          wr_en,
  input  wire dsc_pkg::slot_id_t             wr_idx,
  input  wire logic [dsc_pkg::ADDR_W-1:0]    wr_tag,
  output dsc_pkg::scan_rec_t                 rec_out
);

  localparam dsc_pkg::slot_id_t MY_ID = dsc_pkg::SLOT_ID_W'(INDEX);

  logic                       valid_r;
  logic [dsc_pkg::ADDR_W-1:0] tag_r;
  dsc_pkg::scan_rec_t         rec_r;
  dsc_pkg::scan_rec_t         rec_nxt;
  logic                       match;
  logic                       sel;

  assign match = valid_r && (tag_r == addr);
  assign sel   = wr_en && (wr_idx == MY_ID);

  always_comb begin
    rec_nxt = rec_in;
    if (!rec_in.hit_f && match) begin
      rec_nxt.hit_f   = 1'b1;
      rec_nxt.hit_idx = MY_ID;
    end
    if (!valid_r) begin
      if (MY_ID >= ptr) begin
        if (!rec_in.hi_f) begin
          rec_nxt.hi_f   = 1'b1;
          rec_nxt.hi_idx = MY_ID;
        end
      end else begin
        if (!rec_in.lo_f) begin
          rec_nxt.lo_f   = 1'b1;
          rec_nxt.lo_idx = MY_ID;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rec_r   <= '0;
    end else begin
      rec_r <= rec_nxt;
      if (sel) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      tag_r <= wr_tag;
    end
  end

  assign rec_out = rec_r;

endmodule
`default_nettype wire

/* rtl/decoded_instruction_slot_cache_unit.sv */
// Decoded-instruction slot cache, fully associative, round-robin fill.
// Input channel: in_valid / in_stall with in_fetch_address (64 bits), one
// lookup per transaction. Result channel: out_valid / out_stall with out_hit,
// out_slot_index (low 7 bits of the slot) and out_rebase_fetch.
// Each slot is a cell in a chain; a scan record walks the chain one cell per
// cycle, collecting the lowest matching slot and the free slots at/after and
// before the rotate pointer. A new lookup is taken only in the idle state, after
// the previous scan has written its result; the chain length sets the scan
// time. in_stall is high while a lookup is in
// flight. The input side may accept a new lookup while a previous result still
// waits in the output register; a finished scan holds until that register is
// free, so a stalled receiver backs up into in_stall.
// Reset (synchronous, active low) clears all slot valid bits, the rotate
// pointer and the output valid bit, and sets the last-was-miss flag.
`default_nettype none
module decoded_instruction_slot_cache_unit #(
  parameter int SLOT_COUNT = 128
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [dsc_pkg::ADDR_W-1:0]        in_fetch_address,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_hit,
  output logic [dsc_pkg::SLOT_OUT_W-1:0]         out_slot_index,
  output logic                                   out_rebase_fetch
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

  dsc_pkg::state_t            state_r, state_nxt;
  logic                       start_r;
  logic [dsc_pkg::ADDR_W-1:0] addr_r;
  logic [IDX_W-1:0]           ptr_r, ptr_nxt;
  logic                       last_miss_r;
  dsc_pkg::scan_rec_t         fin_r;
  logic                       out_valid_r;
  logic                       out_hit_r;
  logic [dsc_pkg::SLOT_OUT_W-1:0] out_slot_r;
  logic                       out_rebase_r;

  logic                       accept;
  logic                       commit;
  logic [IDX_W-1:0]           used;
  logic [IDX_W-1:0]           ptr_succ;
  dsc_pkg::scan_rec_t         chain [SLOT_COUNT+1];

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dsc_pkg::ST_IDLE: if (accept) state_nxt = dsc_pkg::ST_SCAN;
      dsc_pkg::ST_SCAN: if (chain[SLOT_COUNT].tok) state_nxt = dsc_pkg::ST_DONE;
      dsc_pkg::ST_DONE: if (commit) state_nxt = dsc_pkg::ST_IDLE;
      default:          state_nxt = dsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    commit   = 1'b0;
    unique case (state_r)
      dsc_pkg::ST_IDLE: in_stall = 1'b0;
      dsc_pkg::ST_SCAN: in_stall = 1'b1;
      dsc_pkg::ST_DONE: commit   = !out_valid_r || !out_stall;
      default:          in_stall = 1'b1;
    endcase
  end

  always_comb begin
    chain[0]     = '0;
    chain[0].tok = start_r;
  end

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    dsc_cell #(.INDEX(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .rec_in (chain[i]),
      .addr   (addr_r),
      .ptr    (dsc_pkg::SLOT_ID_W'(ptr_r)),
      .wr_en  (commit && !fin_r.hit_f),
      .wr_idx (dsc_pkg::SLOT_ID_W'(used)),
      .wr_tag (addr_r),
      .rec_out(chain[i+1])
    );
  end

  assign ptr_succ = (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;

  always_comb begin
    if (fin_r.hit_f) begin
      used = IDX_W'(fin_r.hit_idx);
    end else if (fin_r.hi_f) begin
      used = IDX_W'(fin_r.hi_idx);
    end else if (fin_r.lo_f) begin
      used = IDX_W'(fin_r.lo_idx);
    end else begin
      used = ptr_succ;
    end
    ptr_nxt = (used == LAST_SLOT) ? '0 : used + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsc_pkg::ST_IDLE;
      start_r     <= 1'b0;
      ptr_r       <= '0;
      last_miss_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
      if (commit) begin
        ptr_r       <= ptr_nxt;
        last_miss_r <= !fin_r.hit_f;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_fetch_address;
    end
    if (state_r == dsc_pkg::ST_SCAN && chain[SLOT_COUNT].tok) begin
      fin_r <= chain[SLOT_COUNT];
    end
    if (commit) begin
      out_hit_r    <= fin_r.hit_f;
      out_slot_r   <= dsc_pkg::SLOT_OUT_W'(used);
      out_rebase_r <= !fin_r.hit_f && !last_miss_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_slot_index   = out_slot_r;
  assign out_rebase_fetch = out_rebase_r;

endmodule
`default_nettype wire

/* rtl/dsc_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module dsc_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic                              out_hit,
  input wire logic [dsc_pkg::SLOT_OUT_W-1:0]    out_slot_index,
  input wire logic                              out_rebase_fetch
);

  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid)
  `ASSERT_CLK(a_out_stable, clk, rst_n, (out_valid && out_stall) |=> $stable(out_slot_index))
  `ASSERT_NEVER(a_hit_no_rebase, clk, rst_n, out_valid && out_hit && out_rebase_fetch)
  `ASSERT_CLK(a_busy_after_in, clk, rst_n, (in_valid && !in_stall) |=> in_stall)
  `ASSERT_CLK(a_no_quick_result, clk, rst_n, (in_valid && !in_stall) |=> !$rose(out_valid))

endmodule

bind decoded_instruction_slot_cache_unit dsc_checker u_dsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_hit         (out_hit),
  .out_slot_index  (out_slot_index),
  .out_rebase_fetch(out_rebase_fetch)
);
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  localparam int SLOTS = 128;
  localparam int DIR_ROWS = 16;
  localparam int RAND_ITEMS = 2000;
  localparam int TOTAL = DIR_ROWS + RAND_ITEMS;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 700;

  typedef struct packed {
    logic                           hit;
    logic [dsc_pkg::SLOT_OUT_W-1:0] slot;
    logic                           rebase;
  } lookup_res_t;

  typedef struct packed {
    logic [dsc_pkg::ADDR_W-1:0] addr;
    logic                       known;
    lookup_res_t                res;
  } dir_row_t;

  // known rows carry the expected result; the rest go through the predictor
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{64'h0000_0000_0000_0000, 1'b1, '{1'b0, 7'd0, 1'b0}},
    '{64'h0000_0000_0000_0000, 1'b1, '{1'b1, 7'd0, 1'b0}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 7'd1, 1'b1}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b1, 7'd1, 1'b0}},
    '{64'h0000_0000_0000_0000, 1'b1, '{1'b1, 7'd0, 1'b0}},
    '{64'h0000_0000_0000_0001, 1'b1, '{1'b0, 7'd2, 1'b1}},
    '{64'h8000_0000_0000_0000, 1'b1, '{1'b0, 7'd3, 1'b0}},
    '{64'h0000_0000_0000_0001, 1'b1, '{1'b1, 7'd2, 1'b0}},
    '{64'h8000_0000_0000_0000, 1'b1, '{1'b1, 7'd3, 1'b0}},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{1'b0, 7'd4, 1'b1}},
    '{64'h5555_5555_5555_5555, 1'b1, '{1'b0, 7'd5, 1'b0}},
    '{64'h0000_0000_0000_0000, 1'b1, '{1'b1, 7'd0, 1'b0}},
    '{64'h0000_0000_0000_0002, 1'b1, '{1'b0, 7'd6, 1'b1}},
    '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0},
    '{64'h0000_0001_0000_0000, 1'b0, '0},
    '{64'h0000_0000_0000_0001, 1'b0, '0}
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [dsc_pkg::ADDR_W-1:0]     in_fetch_address = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_hit;
  logic [dsc_pkg::SLOT_OUT_W-1:0] out_slot_index;
  logic                           out_rebase_fetch;

  decoded_instruction_slot_cache_unit #(.SLOT_COUNT(SLOTS)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_fetch_address (in_fetch_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_slot_index   (out_slot_index),
    .out_rebase_fetch (out_rebase_fetch)
  );

  initial forever #5 clk = ~clk;

  bit                         slot_live [SLOTS];
  logic [dsc_pkg::ADDR_W-1:0] slot_addr [SLOTS];
  int unsigned                rot_ptr = 0;
  bit                         prev_miss = 1'b1;

  lookup_res_t                due_results [$];
  logic [dsc_pkg::ADDR_W-1:0] missed_addrs [$];
  int unsigned                cycles = 0;
  int                         errors = 0;
  int                         n_recv = 0;
  int                         n_hits = 0;
  int                         n_misses = 0;
  int                         n_rebase = 0;
  int                         n_evict = 0;
  bit                         quiet = 1'b0;

  function automatic lookup_res_t cache_lookup(logic [dsc_pkg::ADDR_W-1:0] addr);
    int unsigned used;
    int unsigned s;
    bit found;
    bit got_free;
    lookup_res_t r;
    found = 1'b0;
    used = 0;
    r = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && slot_live[i] && slot_addr[i] == addr) begin
        used = i;
        found = 1'b1;
      end
    end
    if (found) begin
      prev_miss = 1'b0;
      n_hits++;
    end else begin
      // free slot at or after the pointer, else the one after it
      got_free = 1'b0;
      used = (rot_ptr + 1) % SLOTS;
      for (int k = 0; k < SLOTS; k++) begin
        s = (rot_ptr + k) % SLOTS;
        if (!got_free && !slot_live[s]) begin
          used = s;
          got_free = 1'b1;
        end
      end
      if (!got_free) n_evict++;
      slot_live[used] = 1'b1;
      slot_addr[used] = addr;
      r.rebase = !prev_miss;
      if (r.rebase) n_rebase++;
      prev_miss = 1'b1;
      n_misses++;
    end
    rot_ptr = (used + 1) % SLOTS;
    r.hit = found;
    r.slot = dsc_pkg::SLOT_OUT_W'(used);
    return r;
  endfunction

  task automatic offer(input logic [dsc_pkg::ADDR_W-1:0] addr,
                       output lookup_res_t predicted);
    in_valid <= 1'b1;
    in_fetch_address <= addr;
    do @(posedge clk); while (in_stall);
    predicted = cache_lookup(addr);
  endtask

  initial begin
    logic [dsc_pkg::ADDR_W-1:0] addr;
    lookup_res_t pred;
    int sel;
    int span;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int n = 0; n < TOTAL; n++) begin
      if (n < DIR_ROWS) begin
        addr = DIR_TABLE[n].addr;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 45 && missed_addrs.size() > 0) begin
          span = (missed_addrs.size() < 110) ? missed_addrs.size() : 110;
          addr = missed_addrs[missed_addrs.size() - 1 - $urandom_range(0, span - 1)];
        end else if (sel < 52 && missed_addrs.size() > 0) begin
          addr = missed_addrs[$urandom_range(0, missed_addrs.size() - 1)];
        end else if (sel < 57) begin
          addr = in_fetch_address;
        end else if (sel < 60) begin
          case ($urandom_range(0, 2))
            0: addr = '0;
            1: addr = '1;
            default: addr = 64'h1 << $urandom_range(0, 63);
          endcase
        end else begin
          addr = {$urandom, $urandom};
        end
      end
      offer(addr, pred);
      if (!pred.hit) begin
        missed_addrs.push_back(addr);
        if (missed_addrs.size() > 300) void'(missed_addrs.pop_front());
      end
      if (n < DIR_ROWS && DIR_TABLE[n].known) due_results.push_back(DIR_TABLE[n].res);
      else due_results.push_back(pred);
      if (n == TOTAL - 150) quiet <= 1'b1;
      if (n == DIR_ROWS + RAND_ITEMS / 2) begin
        // drain everything before going on
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
      end else if (n < TOTAL - 150 && (n / 100) % 4 != 3 && $urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
    $display("tb: %0d lookups: %0d hits, %0d misses, %0d rebases, %0d full-store evictions",
             TOTAL, n_hits, n_misses, n_rebase, n_evict);
    $display("tb: %0d results checked, %0d mismatches", n_recv, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  int hold_left = 0;
  int stall_left = 0;

  always @(posedge clk) begin : rx
    lookup_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: unexpected transaction hit=%0b slot=%0d rebase=%0b",
                   out_hit, out_slot_index, out_rebase_fetch);
      end else begin
        want = due_results.pop_front();
        n_recv++;
        if (out_hit !== want.hit || out_slot_index !== want.slot ||
            out_rebase_fetch !== want.rebase) begin
          errors++;
          if (errors <= 10)
            $display("tb: result %0d exp hit=%0b slot=%0d rebase=%0b, %s%0b %s%0d %s%0b",
                     n_recv, want.hit, want.slot, want.rebase,
                     "got hit=", out_hit, "slot=", out_slot_index,
                     "rebase=", out_rebase_fetch);
        end
        if (n_recv == 200 || n_recv == 1100) hold_left = HOLD_CYCLES;
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && (cycles / 3000) % 4 != 3 && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
